// ===== hw/rtl/pnoise_pkg.sv =====
`default_nettype none
package pnoise_pkg;

  localparam logic       CMD_LOAD = 1'b0;
  localparam logic       CMD_EVAL = 1'b1;

  localparam logic       CFG_OCTAVE_COUNT = 1'b0;
  localparam logic       CFG_PERSISTENCE  = 1'b1;
  localparam int         CFG_IDX_W  = 1;
  localparam int         CFG_DATA_W = 17;

  localparam int         FRAC_W  = 16;
  localparam int         GRAD_W  = 19;
  localparam int         MUL_W   = 37;
  localparam int         OUT_W   = 18;
  localparam int         AMP_W   = 17;
  localparam int         QUEUE_DEPTH = 2;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [17:0] FADE_K  = 18'd196608;
  localparam logic [17:0] OUT_MAX = 18'd131071;
  localparam logic [17:0] OUT_MIN_MAG = 18'd131072;

  // per-octave step numbers of the back end
  localparam logic [3:0] PH_ROOT  = 4'd0;
  localparam logic [3:0] PH_HASHA = 4'd1;
  localparam logic [3:0] PH_HASHB = 4'd2;
  localparam logic [3:0] PH_GRAD  = 4'd3;
  localparam logic [3:0] PH_MULX  = 4'd4;
  localparam logic [3:0] PH_SUMX  = 4'd5;
  localparam logic [3:0] PH_MULY  = 4'd6;
  localparam logic [3:0] PH_SUMY  = 4'd7;
  localparam logic [3:0] PH_AMP   = 4'd8;
  localparam logic [3:0] PH_ACC   = 4'd9;

  typedef struct packed {
    logic        is_load;
    logic [7:0]  perm_index;
    logic [7:0]  perm_value;
    logic [31:0] x_coord;
    logic [31:0] y_coord;
  } item_t;

  function automatic logic signed [GRAD_W-1:0] grad_f(
    input logic [1:0]               h,
    input logic signed [GRAD_W-1:0] dx,
    input logic signed [GRAD_W-1:0] dy
  );
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    gx = h[0] ? dx : -dx;
    gy = h[1] ? dy : -dy;
    return gx + gy;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pnoise_in_if.sv =====
`default_nettype none
interface pnoise_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  perm_index;
  logic [7:0]  perm_value;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;

  modport source (output valid, cmd, perm_index, perm_value, x_coord, y_coord,
                  input ready);
  modport sink (input valid, cmd, perm_index, perm_value, x_coord, y_coord,
                output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pnoise_out_if.sv =====
`default_nettype none
interface pnoise_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink (input valid, noise_value, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pnoise_cfg_if.sv =====
`default_nettype none
interface pnoise_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [16:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pnoise_front.sv =====
`default_nettype none
module pnoise_front
  import pnoise_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  pnoise_in_if.sink   in_ch,
  output logic        q_valid,
  input  wire logic   q_ready,
  output item_t       q_item
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  item_t           slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;
  logic            push, pop;
  item_t           item_in;

  assign in_ch.ready = (cnt_r < (PW+1)'(QUEUE_DEPTH));
  assign push = in_ch.valid && in_ch.ready;
  assign pop  = q_valid && q_ready;
  assign q_valid = (cnt_r != '0);
  assign q_item  = slot_r[rd_ptr_r];

  always_comb begin
    item_in.is_load    = (in_ch.cmd == CMD_LOAD);
    item_in.perm_index = in_ch.perm_index;
    item_in.perm_value = in_ch.perm_value;
    item_in.x_coord    = in_ch.x_coord;
    item_in.y_coord    = in_ch.y_coord;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item_in;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pnoise_div.sv =====
`default_nettype none
module pnoise_div
  import pnoise_pkg::*;
#(
  parameter int TW = 41,
  parameter int AW = 21
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [TW-1:0] dividend,
  input  wire logic [AW-1:0]        divisor,
  output logic                      done,
  input  wire logic                 ack,
  output logic signed [OUT_W-1:0]   result
);

  localparam int CW = $clog2(TW + 1);

  logic          busy_r, done_r, neg_r;
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] rem_r, den_r;
  logic [TW-1:0] quo_r;
  logic [AW:0]   trial;
  logic          qbit;
  logic [AW-1:0] rem_nxt;

  // restoring division on the magnitude, one quotient bit per cycle
  always_comb begin
    trial   = {rem_r, quo_r[TW-1]};
    qbit    = (trial >= {1'b0, den_r});
    rem_nxt = qbit ? AW'(trial - {1'b0, den_r}) : AW'(trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(TW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else if (ack) begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[TW-1];
      quo_r <= dividend[TW-1] ? TW'(-dividend) : TW'(dividend);
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[TW-2:0], qbit};
    end
  end

  assign done = done_r;

  always_comb begin
    if (!neg_r) begin
      result = (quo_r > TW'(OUT_MAX)) ? OUT_MAX : quo_r[OUT_W-1:0];
    end else begin
      result = (quo_r > TW'(OUT_MIN_MAG)) ? OUT_MIN_MAG : OUT_W'(-quo_r[OUT_W-1:0]);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pnoise_back.sv =====
`default_nettype none
module pnoise_back
  import pnoise_pkg::*;
#(
  parameter int PERM_SIZE   = 256,
  parameter int MAX_OCTAVES = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              q_valid,
  output logic                                   q_ready,
  input  wire item_t                             q_item,
  input  wire logic [$clog2(MAX_OCTAVES+1)-1:0]  n_eff,
  input  wire logic [AMP_W-1:0]                  pers_eff,
  pnoise_out_if.source                           out_ch
);

  localparam int IW = $clog2(PERM_SIZE);
  localparam int NW = $clog2(MAX_OCTAVES + 1);
  localparam int TW = MUL_W + $clog2(MAX_OCTAVES) + 1;
  localparam int AW = AMP_W + $clog2(MAX_OCTAVES) + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_OCT  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]   perm_mem [PERM_SIZE];
  logic [7:0]   rdat0_r, rdat1_r;
  logic [IW-1:0] raddr0, raddr1;

  logic [3:0]   ph_r;
  logic [NW-1:0] oct_r, n_last_r;
  logic [31:0]  x_r, y_r;
  logic [AMP_W-1:0] pers_r, amp_r;
  logic signed [TW-1:0] total_r;
  logic [AW-1:0] asum_r;

  logic [31:0]  sqx_r, sqy_r;
  logic [15:0]  u_r, v_r;
  logic [IW-1:0] b_r;
  logic [7:0]   haa_r, hab_r;
  logic signed [GRAD_W-1:0] g0_r, g1_r, g2_r, g3_r;
  logic signed [MUL_W-1:0]  m0_r, m1_r, m2_r, m3_r, n0_r, n1_r;
  logic signed [GRAD_W-1:0] i1_r, i2_r, layer_r;
  logic signed [MUL_W-1:0]  prod_r;
  logic [2*AMP_W-1:0]       ampp_r;

  logic [IW-1:0] cx, cy, a_addr;
  logic [15:0]   fx, fy;
  logic [17:0]   kx, ky;
  logic [49:0]   fux, fvy;
  logic signed [GRAD_W-1:0] dx0, dx1, dy0, dy1;
  logic [16:0]   wu, wv;
  logic signed [MUL_W:0] s1, s2, s3;

  logic          pop, is_eval, div_start, div_done, div_ack;
  logic signed [OUT_W-1:0] div_res;
  logic          out_valid_r;
  logic signed [OUT_W-1:0] out_value_r;
  logic          out_free;

  assign q_ready = (state_r == S_IDLE);
  assign pop     = q_valid && q_ready;
  assign is_eval = !q_item.is_load;
  assign out_free = !out_valid_r || out_ch.ready;

  assign cx = x_r[FRAC_W +: IW];
  assign cy = y_r[FRAC_W +: IW];
  assign fx = x_r[FRAC_W-1:0];
  assign fy = y_r[FRAC_W-1:0];
  assign a_addr = IW'(rdat0_r) + cy;

  always_comb begin
    case (ph_r)
      PH_HASHA: begin
        raddr0 = a_addr;
        raddr1 = a_addr + 1'b1;
      end
      PH_HASHB: begin
        raddr0 = b_r;
        raddr1 = b_r + 1'b1;
      end
      default: begin
        raddr0 = cx;
        raddr1 = cx + 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop && q_item.is_load) begin
      perm_mem[IW'(q_item.perm_index)] <= q_item.perm_value;
    end
    rdat0_r <= perm_mem[raddr0];
    rdat1_r <= perm_mem[raddr1];
  end

  // fade: t^2 * (3 - 2t) with t in Q0.16
  always_comb begin
    kx  = FADE_K - {1'b0, fx, 1'b0};
    ky  = FADE_K - {1'b0, fy, 1'b0};
    fux = sqx_r * kx;
    fvy = sqy_r * ky;
    dx0 = $signed({3'b000, fx});
    dy0 = $signed({3'b000, fy});
    dx1 = dx0 - $signed({2'b00, ONE_Q16});
    dy1 = dy0 - $signed({2'b00, ONE_Q16});
    wu  = ONE_Q16 - {1'b0, u_r};
    wv  = ONE_Q16 - {1'b0, v_r};
    s1  = m0_r + m1_r;
    s2  = m2_r + m3_r;
    s3  = n0_r + n1_r;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OCT) begin
      case (ph_r)
        PH_ROOT: begin
          sqx_r <= fx * fx;
          sqy_r <= fy * fy;
        end
        PH_HASHA: begin
          u_r <= fux[47:32];
          v_r <= fvy[47:32];
          b_r <= IW'(rdat1_r) + cy;
        end
        PH_HASHB: begin
          haa_r <= rdat0_r;
          hab_r <= rdat1_r;
        end
        PH_GRAD: begin
          g0_r <= grad_f(haa_r[1:0], dx0, dy0);
          g1_r <= grad_f(rdat0_r[1:0], dx1, dy0);
          g2_r <= grad_f(hab_r[1:0], dx0, dy1);
          g3_r <= grad_f(rdat1_r[1:0], dx1, dy1);
        end
        PH_MULX: begin
          m0_r <= $signed({1'b0, wu}) * g0_r;
          m1_r <= $signed({2'b00, u_r}) * g1_r;
          m2_r <= $signed({1'b0, wu}) * g2_r;
          m3_r <= $signed({2'b00, u_r}) * g3_r;
        end
        PH_SUMX: begin
          i1_r <= s1[FRAC_W +: GRAD_W];
          i2_r <= s2[FRAC_W +: GRAD_W];
        end
        PH_MULY: begin
          n0_r <= $signed({1'b0, wv}) * i1_r;
          n1_r <= $signed({2'b00, v_r}) * i2_r;
        end
        PH_SUMY: begin
          layer_r <= s3[FRAC_W +: GRAD_W];
        end
        PH_AMP: begin
          prod_r <= layer_r * $signed({1'b0, amp_r});
          ampp_r <= amp_r * pers_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    div_ack   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (pop && is_eval) begin
          state_nxt = S_OCT;
        end
      end
      S_OCT: begin
        if (ph_r == PH_ACC && oct_r == n_last_r) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        div_start = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (div_done && out_free) begin
          div_ack   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= PH_ROOT;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        ph_r <= PH_ROOT;
      end else if (state_r == S_OCT) begin
        ph_r <= (ph_r == PH_ACC) ? PH_ROOT : ph_r + 1'b1;
      end
      if (div_ack) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_eval) begin
      x_r      <= q_item.x_coord;
      y_r      <= q_item.y_coord;
      oct_r    <= '0;
      n_last_r <= n_eff - 1'b1;
      pers_r   <= pers_eff;
      amp_r    <= ONE_Q16;
      total_r  <= '0;
      asum_r   <= '0;
    end else if (state_r == S_OCT && ph_r == PH_ACC) begin
      total_r <= total_r + TW'(prod_r);
      asum_r  <= asum_r + AW'(amp_r);
      amp_r   <= ampp_r[FRAC_W +: AMP_W];
      x_r     <= {x_r[30:0], 1'b0};
      y_r     <= {y_r[30:0], 1'b0};
      oct_r   <= oct_r + 1'b1;
    end
    if (div_ack) begin
      out_value_r <= div_res;
    end
  end

  pnoise_div #(
    .TW (TW),
    .AW (AW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (total_r),
    .divisor  (asum_r),
    .done     (div_done),
    .ack      (div_ack),
    .result   (div_res)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.noise_value = out_value_r;

endmodule
`default_nettype wire

// ===== hw/rtl/perlin_noise_2d_octaves_core.sv =====
`default_nettype none
// Fractal 2D gradient noise: sums octave_count layers (clamped to the range
// 1..MAX_OCTAVES) of lattice noise at a signed Q16.16 point and returns the
// amplitude-normalized sum as saturated signed Q2.16. The permutation table
// has no reset value and must be loaded in full with load commands before the
// first evaluate. A load gives no result. An evaluate runs each octave through
// a chain of dependent table reads and interpolation multiplies, then a
// bit-serial divider. A two-entry queue in front of the execution unit keeps
// taking items while it works, until it is full.
module perlin_noise_2d_octaves_core
  import pnoise_pkg::*;
#(
  parameter int PERM_SIZE   = 256,
  parameter int MAX_OCTAVES = 8
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  pnoise_in_if.sink    in_ch,
  pnoise_out_if.source out_ch,
  pnoise_cfg_if.sink   cfg_ch
);

  localparam int NW = $clog2(MAX_OCTAVES + 1);

  logic [3:0]        oct_cfg_r;
  logic [AMP_W-1:0]  pers_cfg_r;
  logic [NW-1:0]     n_eff;
  logic [AMP_W-1:0]  pers_eff;
  logic              q_valid, q_ready;
  item_t             q_item;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_cfg_r  <= 4'd1;
      pers_cfg_r <= 17'd32768;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_OCTAVE_COUNT: oct_cfg_r  <= cfg_ch.data[3:0];
        CFG_PERSISTENCE:  pers_cfg_r <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (oct_cfg_r == 4'd0) begin
      n_eff = NW'(1);
    end else if (int'(oct_cfg_r) > MAX_OCTAVES) begin
      n_eff = NW'(MAX_OCTAVES);
    end else begin
      n_eff = NW'(oct_cfg_r);
    end
    pers_eff = (pers_cfg_r > ONE_Q16) ? ONE_Q16 : pers_cfg_r;
  end

  pnoise_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  pnoise_back #(
    .PERM_SIZE   (PERM_SIZE),
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .n_eff    (n_eff),
    .pers_eff (pers_eff),
    .out_ch   (out_ch)
  );

  // the back end only takes a queued item when no result is being computed
  a_pop_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && q_ready && !out_ch.valid |=> !out_ch.valid)
    else $error("result appeared right after a queue pop");

  // the queue only fills up through an input transfer
  a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ch.ready) |-> $past(in_ch.valid && in_ch.ready))
    else $error("input ready dropped without a transfer");

  // a load never leaves the back end busy
  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && q_ready && q_item.is_load |=> q_ready)
    else $error("back end busy after a load");

endmodule
`default_nettype wire
